[rtl/core/psf_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the sine-well force block.
package psf_pkg;

  localparam int SINE_TABLE_DEPTH       = 1024;
  localparam int POSITION_FRACTION_BITS = 12;

  localparam int AW  = $clog2(SINE_TABLE_DEPTH);   // table address width
  localparam int QW  = AW + 2;                     // full-turn phase width
  localparam int FB  = POSITION_FRACTION_BITS;
  localparam int QTR = 1 << (FB - 2);              // 0.25 in position units

  localparam int QUEUE_DEPTH = 4;
  localparam int QPW         = $clog2(QUEUE_DEPTH);

  localparam int ROM_W   = 18;
  localparam int DIST_W  = 16;
  localparam int D2_W    = 2 * DIST_W;
  localparam int EOP_W   = D2_W;
  localparam int FPROD_W = 32 + ROM_W;
  localparam int EPROD_W = 32 + EOP_W;

  localparam logic [ROM_W-1:0] ONE_Q17 = ROM_W'(131072);

  // region edges, 18-bit signed
  localparam logic signed [17:0] EDGE_LWALL = 18'(-5 * QTR);
  localparam logic signed [17:0] EDGE_W3    = 18'(-1 * QTR);
  localparam logic signed [17:0] EDGE_W4    = 18'(3 * QTR);
  localparam logic signed [17:0] EDGE_RWALL = 18'(7 * QTR);

  // Q24 force and energy coefficients
  localparam logic [31:0] C_4PI   = 32'd210828714;
  localparam logic [31:0] C_6PI   = 32'd316243071;
  localparam logic [31:0] C_8PI   = 32'd421657428;
  localparam logic [31:0] C_4PI2  = 32'd662337939;
  localparam logic [31:0] C_8PI2  = 32'd1324675879;
  localparam logic [31:0] C_16PI2 = 32'd2649351758;

  localparam int WALL_FSH = FB + 8;
  localparam int WALL_ESH = 2 * FB + 8;
  localparam int WELL_FSH = 25;

  localparam logic [47:0] SUM_MAX = '1;

  typedef enum logic [2:0] {
    REG_LWALL = 3'd0,
    REG_WELL2 = 3'd1,
    REG_WELL3 = 3'd2,
    REG_WELL4 = 3'd3,
    REG_RWALL = 3'd4
  } psf_region_e;

  typedef struct packed {
    logic signed [15:0] position;
    logic               last;
  } psf_in_t;

  typedef struct packed {
    logic signed [31:0] force_out;
    logic [31:0]        energy_out;
    logic [47:0]        total_energy;
    logic               total_valid;
  } psf_out_t;

  // classified item, front to back
  typedef struct packed {
    psf_region_e       region;
    logic [DIST_W-1:0] wdist;
    logic              neg;
    logic [QW-1:0]     ph_sin;
    logic [QW-1:0]     ph_cos;
    logic              last;
  } psf_cmd_t;

  typedef logic [ROM_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint SER_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  function automatic sine_rom_t build_rom();
    sine_rom_t rom;
    longint    a;
    longint    t;
    longint    sum;
    longint    v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      a   = (longint'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      t   = a;
      sum = a;
      for (int k = 0; k < 7; k++) begin
        t = (t * a) >>> 30;
        t = ((t * a) >>> 30) / SER_DIV[k];
        if ((k % 2) == 0) sum = sum - t;
        else              sum = sum + t;
      end
      if (sum < 0) sum = 0;
      v = (sum + 4096) >>> 13;
      if (v > 262143) v = 262143;
      rom[i] = ROM_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

endpackage

[rtl/core/psf_front.sv]
// Front end: classifies a position into wall or well region, distance and phase.
module psf_front (
  input  psf_pkg::psf_in_t  in_data_i,
  output psf_pkg::psf_cmd_t cmd_o
);
  import psf_pkg::*;

  logic signed [17:0]   p;
  logic signed [17:0]   dl;
  logic signed [17:0]   dr;
  logic [FB-1:0]        frac;
  logic [FB+QW-1:0]     ph_wide;
  logic [QW-1:0]        ph;

  assign p       = {{2{in_data_i.position[15]}}, in_data_i.position};
  assign dl      = EDGE_LWALL - p;          // |x + 1.25| on the left wall
  assign dr      = p - EDGE_RWALL;          // x - 1.75 on the right wall
  assign frac    = in_data_i.position[FB-1:0];
  assign ph_wide = {frac, {QW{1'b0}}} >> FB;
  assign ph      = ph_wide[QW-1:0];

  always_comb begin
    cmd_o        = '0;
    cmd_o.last   = in_data_i.last;
    cmd_o.ph_sin = ph;
    cmd_o.ph_cos = ph + QW'(SINE_TABLE_DEPTH);
    if (p < EDGE_LWALL) begin
      cmd_o.region = REG_LWALL;
      cmd_o.wdist  = DIST_W'(dl);
      cmd_o.neg    = 1'b0;
    end else if (p >= EDGE_RWALL) begin
      cmd_o.region = REG_RWALL;
      cmd_o.wdist  = DIST_W'(dr);
      cmd_o.neg    = 1'b1;
    end else if (p < EDGE_W3) begin
      cmd_o.region = REG_WELL2;
    end else if (p < EDGE_W4) begin
      cmd_o.region = REG_WELL3;
    end else begin
      cmd_o.region = REG_WELL4;
    end
  end

endmodule

[rtl/core/psf_queue.sv]
// Short FIFO that decouples the classifier from the arithmetic pipeline.
module psf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  psf_pkg::psf_cmd_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output psf_pkg::psf_cmd_t pop_data_o
);
  import psf_pkg::*;

  psf_cmd_t     mem_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPW:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == (QPW+1)'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPW'(push_i);
    rd_ptr_d = rd_ptr_q + QPW'(pop_i);
    cnt_d    = cnt_q + (QPW+1)'(push_i) - (QPW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

[rtl/core/psf_back.sv]
// Back end: sine ROM read, coefficient multiply, rounding, saturation and running total.
module psf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  psf_pkg::psf_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output psf_pkg::psf_out_t out_data_o
);
  import psf_pkg::*;

  logic en;

  // stage 1: ROM reads, distance square
  logic              v1_q;
  psf_region_e       reg1_q;
  logic [ROM_W-1:0]  rs_q, rc_q;
  logic              s_one_q, s_neg_q, c_one_q, c_neg_q;
  logic [D2_W-1:0]   d2_q;
  logic [DIST_W-1:0] dist1_q;
  logic              neg1_q, last1_q;

  // stage 2: products
  logic               v2_q;
  psf_region_e        reg2_q;
  logic [FPROD_W-1:0] fp_q;
  logic [EPROD_W-1:0] ep_q;
  logic               fneg2_q, last2_q;

  logic [47:0] sum_q, sum_d;
  logic        ov_q;
  psf_out_t    od_q, od_d;

  logic [AW-1:0] s_idx, c_idx;
  logic          s_one, c_one;

  assign en          = !ov_q || out_ready_i;
  assign cmd_pop_o   = en && cmd_valid_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // mirror the quarter table by quadrant; odd quadrant at r == 0 is full scale
  always_comb begin
    s_idx = cmd_i.ph_sin[QW-2] ? AW'(SINE_TABLE_DEPTH) - cmd_i.ph_sin[AW-1:0]
                               : cmd_i.ph_sin[AW-1:0];
    c_idx = cmd_i.ph_cos[QW-2] ? AW'(SINE_TABLE_DEPTH) - cmd_i.ph_cos[AW-1:0]
                               : cmd_i.ph_cos[AW-1:0];
    s_one = cmd_i.ph_sin[QW-2] && (cmd_i.ph_sin[AW-1:0] == '0);
    c_one = cmd_i.ph_cos[QW-2] && (cmd_i.ph_cos[AW-1:0] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q    <= SINE_ROM[s_idx];
      rc_q    <= SINE_ROM[c_idx];
      s_one_q <= s_one;
      c_one_q <= c_one;
      s_neg_q <= cmd_i.ph_sin[QW-1];
      c_neg_q <= cmd_i.ph_cos[QW-1];
      reg1_q  <= cmd_i.region;
      d2_q    <= D2_W'(cmd_i.wdist * cmd_i.wdist);
      dist1_q <= cmd_i.wdist;
      neg1_q  <= cmd_i.neg;
      last1_q <= cmd_i.last;
    end
  end

  // stage 2 operand select
  logic [ROM_W-1:0] s_mag, c_mag;
  logic [EOP_W-1:0] e_op;
  logic [ROM_W-1:0] f_op;
  logic             f_neg;
  logic [31:0]      f_coef, e_coef;
  logic             wall1;

  always_comb begin
    s_mag = s_one_q ? ONE_Q17 : rs_q;
    c_mag = c_one_q ? ONE_Q17 : rc_q;
    wall1 = (reg1_q == REG_LWALL) || (reg1_q == REG_RWALL);
    if (wall1) begin
      e_op  = d2_q;
      f_op  = ROM_W'(dist1_q);
      f_neg = neg1_q;
    end else begin
      e_op  = s_neg_q ? EOP_W'(ONE_Q17) - EOP_W'(s_mag) : EOP_W'(ONE_Q17) + EOP_W'(s_mag);
      f_op  = c_mag;
      f_neg = !c_neg_q;          // F = -k cos, negative when cos > 0
    end
    unique case (reg1_q)
      REG_LWALL: begin f_coef = C_8PI2;  e_coef = C_4PI2; end
      REG_WELL2: begin f_coef = C_4PI;   e_coef = 32'd2;  end
      REG_WELL3: begin f_coef = C_6PI;   e_coef = 32'd3;  end
      REG_WELL4: begin f_coef = C_8PI;   e_coef = 32'd4;  end
      REG_RWALL: begin f_coef = C_16PI2; e_coef = C_8PI2; end
      default:   begin f_coef = '0;      e_coef = '0;     end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fp_q    <= FPROD_W'(f_coef * f_op);
      ep_q    <= EPROD_W'(e_coef * e_op);
      reg2_q  <= reg1_q;
      fneg2_q <= f_neg;
      last2_q <= last1_q;
    end
  end

  // stage 3: round, saturate, accumulate
  logic [FPROD_W:0]   f_rnd;
  logic [EPROD_W:0]   e_rnd;
  logic [31:0]        energy;
  logic [48:0]        tot;
  logic [47:0]        tot_sat;
  logic               wall2;

  always_comb begin
    wall2 = (reg2_q == REG_LWALL) || (reg2_q == REG_RWALL);
    if (wall2) begin
      f_rnd = ((FPROD_W+1)'(fp_q) + ((FPROD_W+1)'(1) << (WALL_FSH-1))) >> WALL_FSH;
      e_rnd = ((EPROD_W+1)'(ep_q) + ((EPROD_W+1)'(1) << (WALL_ESH-1))) >> WALL_ESH;
    end else begin
      f_rnd = ((FPROD_W+1)'(fp_q) + ((FPROD_W+1)'(1) << (WELL_FSH-1))) >> WELL_FSH;
      e_rnd = ((EPROD_W+1)'(ep_q) + (EPROD_W+1)'(1)) >> 1;
    end
    energy  = (e_rnd[EPROD_W:32] != '0) ? '1 : e_rnd[31:0];
    tot     = {1'b0, sum_q} + 49'(energy);
    tot_sat = tot[48] ? SUM_MAX : tot[47:0];

    od_d              = od_q;
    od_d.energy_out   = energy;
    od_d.total_energy = tot_sat;
    od_d.total_valid  = last2_q;
    if (fneg2_q) begin
      od_d.force_out = (f_rnd > (FPROD_W+1)'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000
                                                                    : -$signed(f_rnd[31:0]);
    end else begin
      od_d.force_out = (f_rnd > (FPROD_W+1)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                             : $signed(f_rnd[31:0]);
    end
    sum_d = last2_q ? '0 : tot_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en && v2_q) begin
      od_q <= od_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      ov_q  <= 1'b0;
      sum_q <= '0;
    end else if (en) begin
      v1_q <= cmd_valid_i;
      v2_q <= v1_q;
      ov_q <= v2_q;
      if (v2_q) begin
        sum_q <= sum_d;
      end
    end
  end

`ifndef SYNTH
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v2_q && last2_q) |=> (sum_q == '0)) else $error("total not cleared after last");
  a_pop_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (cmd_valid_i && en)) else $error("pop without valid command");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ($stable(sum_q) && ov_q)) else $error("stall lost state");
`endif

endmodule

[rtl/core/piecewise_sine_potential_force.sv]
// Top level: piecewise sine-well potential and force with running energy total.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i   | position in, Q3.12, plus last flag
//  out     | out_valid_o, out_ready_i, out_data_o | force, energy, total, total valid
//
// One item per cycle sustained while out_ready_i is high; each beat passes the
// queue, ROM read, multiply and round/accumulate registers in that order.
// The quarter-wave ROM is a constant table; no clearing pass after reset.
// The four-entry queue lets the front keep taking beats while the output
// stalls; in_ready_o drops only when the queue is full.
// The running total updates when a result enters the output register and
// clears after a beat with last set.
module piecewise_sine_potential_force (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psf_pkg::psf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output psf_pkg::psf_out_t out_data_o
);
  import psf_pkg::*;

  psf_cmd_t cmd_in, cmd_out;
  logic     q_full, q_empty, q_pop, q_push;

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  // classify position into region, wall distance and sine/cosine phase
  psf_front u_front (
    .in_data_i (in_data_i),
    .cmd_o     (cmd_in)
  );

  psf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (cmd_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (cmd_out)
  );

  psf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_full) else $error("input stalled with room in queue");
  a_push_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> q_push) else $error("accepted beat not queued");
  a_out_valid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.total_valid && out_ready_i) |=> !out_valid_o ||
    (out_data_o.total_energy == 48'(out_data_o.energy_out))) else
    $error("total not restarted after last");
`endif

endmodule

[dv/tb_piecewise_sine_potential_force.sv]
// Self-checking testbench for the piecewise sine-well force block.
`timescale 1ns / 100ps

module tb_piecewise_sine_potential_force;
  import psf_pkg::*;

  localparam int N_RANDOM  = 1650;
  localparam int WDOG_MAX  = 5000;  // idle cycles with no beat on either side
  localparam int DRAIN_CYC = 12;    // margin after drain for the pipeline to settle

  // Holds the expected beats and a private copy of the potential math.
  class psf_scoreboard;
    logic [17:0]       qwave [SINE_TABLE_DEPTH];
    psf_out_t          pending [$];
    longint unsigned   energy_acc;
    int                errors;
    int                checked;

    function new();
      longint ang, term, acc, v;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
        ang  = (longint'(i) * 64'sd1686629713) / SINE_TABLE_DEPTH;
        term = ang;
        acc  = ang;
        for (int k = 1; k <= 7; k++) begin
          term = (term * ang) >>> 30;
          term = ((term * ang) >>> 30) / ((2 * k) * (2 * k + 1));
          if (k % 2) acc = acc - term;
          else       acc = acc + term;
        end
        if (acc < 0) acc = 0;
        v = (acc + 4096) >>> 13;
        if (v > 262143) v = 262143;
        qwave[i] = 18'(v);
      end
      energy_acc = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    // quarter-table lookup, full scale past the last entry
    function longint quarter_at(int k);
      if (k >= SINE_TABLE_DEPTH) return 131072;
      return longint'(qwave[k]);
    endfunction

    // signed Q17 sine of a phase in [0, 4*DEPTH)
    function longint sine_of(int ph);
      int quad, r;
      quad = ph / SINE_TABLE_DEPTH;
      r    = ph - quad * SINE_TABLE_DEPTH;
      case (quad)
        0:       return  quarter_at(r);
        1:       return  quarter_at(SINE_TABLE_DEPTH - r);
        2:       return -quarter_at(r);
        default: return -quarter_at(SINE_TABLE_DEPTH - r);
      endcase
    endfunction

    function longint round_off(longint v, int n);
      longint half;
      half = longint'(1) << (n - 1);
      if (v < 0) return -((-v + half) >>> n);
      return (v + half) >>> n;
    endfunction

    // accepted input beat: predict its result and queue it
    function void note(psf_in_t d);
      longint          p, wdist, frc, s, c, amp, cf;
      longint unsigned sq, coef, eng, tot;
      int              ph, phc;
      psf_region_e     reg_id;
      psf_out_t        e;
      p = longint'(d.position);
      if (p < -5 * QTR)     reg_id = REG_LWALL;
      else if (p < -QTR)    reg_id = REG_WELL2;
      else if (p < 3 * QTR) reg_id = REG_WELL3;
      else if (p < 7 * QTR) reg_id = REG_WELL4;
      else                  reg_id = REG_RWALL;
      if (reg_id == REG_LWALL || reg_id == REG_RWALL) begin
        wdist = (reg_id == REG_LWALL) ? p + 5 * QTR : p - 7 * QTR;
        sq    = longint'(wdist * wdist);
        coef  = (reg_id == REG_LWALL) ? 64'd662337939 : 64'd1324675879;
        frc   = round_off(-((reg_id == REG_LWALL) ? 64'sd1324675879 : 64'sd2649351758) * wdist,
                          FB + 8);
        eng   = (coef * sq + (64'd1 << (2 * FB + 7))) >> (2 * FB + 8);
      end else begin
        ph  = int'((longint'(d.position) & ((64'sd1 << FB) - 1)) * (4 * SINE_TABLE_DEPTH)
                   >>> FB);
        phc = (ph + SINE_TABLE_DEPTH) % (4 * SINE_TABLE_DEPTH);
        s   = sine_of(ph);
        c   = sine_of(phc);
        case (reg_id)
          REG_WELL2: begin amp = 2; cf = 210828714; end
          REG_WELL3: begin amp = 3; cf = 316243071; end
          default:   begin amp = 4; cf = 421657428; end
        endcase
        eng = (longint'(amp * (131072 + s)) + 1) >> 1;
        frc = round_off(-cf * c, 25);
      end
      if (eng > 64'hFFFF_FFFF) eng = 64'hFFFF_FFFF;
      if (frc > 64'sd2147483647) frc = 64'sd2147483647;
      if (frc < -64'sd2147483648) frc = -64'sd2147483648;
      tot = energy_acc + eng;
      if (tot > 64'hFFFF_FFFF_FFFF) tot = 64'hFFFF_FFFF_FFFF;
      energy_acc = d.last ? 0 : tot;
      e.force_out    = 32'(frc);
      e.energy_out   = 32'(eng);
      e.total_energy = 48'(tot);
      e.total_valid  = d.last;
      pending.insert(pending.size(), e);
    endfunction

    task report(string what, longint unsigned want, longint unsigned got);
      $display("mismatch %s: expected %0h got %0h (beat %0d)", what, want, got, checked);
      errors++;
    endtask

    task check(psf_out_t got);
      psf_out_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", 0, got.energy_out);
      end else begin
        want = pending.pop_front();
        if (got.force_out !== want.force_out)
          report("force", 32'(want.force_out), 32'(got.force_out));
        if (got.energy_out !== want.energy_out)
          report("energy", want.energy_out, got.energy_out);
        if (got.total_energy !== want.total_energy)
          report("total", want.total_energy, got.total_energy);
        if (got.total_valid !== want.total_valid)
          report("total_valid", want.total_valid, got.total_valid);
      end
      checked++;
    endtask
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  psf_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  psf_out_t out_data_o;

  psf_scoreboard sb = new();
  bit  quiet;        // no idling on either side while set
  int  stall_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  piecewise_sine_potential_force uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Output side: random backpressure, check every accepted beat, watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check(out_data_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WDOG_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
    out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
  end

  // One input beat: hold valid and payload until accepted. Valid stays high
  // straight into the next beat unless a random idle gap is taken first.
  task automatic send(logic signed [15:0] pos, logic lst);
    psf_in_t d;
    d.position = pos;
    d.last     = lst;
    in_data_i  <= d;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(d);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  // wait for every queued result to come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  logic signed [15:0] edges [] = '{
    -16'sd32768, 16'sd32767, -16'sd5121, -16'sd5120, -16'sd1025, -16'sd1024,
    16'sd3071, 16'sd3072, 16'sd7167, 16'sd7168, 16'sd0, 16'sd256, 16'sd512,
    16'sd768, 16'sd1023, -16'sd1, 16'sd4095, -16'sd4096, -16'sd3000, 16'sd5000
  };

  int                 n_wall, n_well;
  logic signed [15:0] pos;

  initial begin
    quiet        = 1'b0;
    stall_cycles = 0;
    n_wall       = 0;
    n_well       = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one-particle system first (empty sum), then region edges and
    // quarter-wave points, then two closing beats with last set
    send(16'sd512, 1'b1);
    foreach (edges[i]) send(edges[i], 1'b0);
    send(16'sd32767, 1'b1);
    send(-16'sd32768, 1'b1);

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 700 && n < 1000);
      if (n == 400) drain();   // sender holds off until the pipe is empty
      case ($urandom_range(9))
        0, 1, 2: pos = 16'($urandom);                          // anywhere
        3:       pos = 16'($urandom_range(32767, 7168));       // right wall
        4:       pos = -16'sd5121 - 16'($urandom_range(27647)); // left wall
        default: pos = -16'sd5120 + 16'($urandom_range(12287)); // wells
      endcase
      if (pos < -16'sd5120 || pos >= 16'sd7168) n_wall++;
      else n_well++;
      send(pos, $urandom_range(19) == 0);
    end

    drain();
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("covered %0d wall and %0d well positions, %0d result beats checked",
             n_wall, n_well, sb.checked);
    $display("directed edges, one-particle systems, backpressure and a quiet stretch");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[piecewise_sine_potential_force.f]
rtl/core/psf_pkg.sv
rtl/core/psf_front.sv
rtl/core/psf_queue.sv
rtl/core/psf_back.sv
rtl/core/piecewise_sine_potential_force.sv
dv/tb_piecewise_sine_potential_force.sv
